FILE: design/pcf_pkg.sv
// shared types and constants for the pattern censor filter
`timescale 1ns / 1ps

package pcf_pkg;

  // window capacity and derived widths
  localparam int MAX_PATTERN = 16;
  localparam int PATTERN_REG_BYTES = 16;
  localparam int LIMIT_CAP = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN
                                                               : PATTERN_REG_BYTES;
  localparam int WIN_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

  // special bytes
  localparam logic [7:0] STAR_BYTE    = 8'h2A;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

endpackage

FILE: design/pcf_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module pcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/pattern_censor_filter.sv
// top level of the streaming pattern censor filter
// sequence: a byte is taken in idle; a full window compares each pattern byte in a read and a check
//   state, then sends a star per pattern byte or pops bytes through a read and a send state; a byte
//   that only fills the window is stored in the drain state. rate is set by the single byte comparator and the
//   one read port of the window ram. one byte is in flight at a time.
// reset: synchronous, clears sequencer, window count, output valid and the pattern registers;
//   window ram contents are not cleared (entries are always written before they are read)
`timescale 1ns / 1ps

module pattern_censor_filter (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [pcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcf_pkg::CFG_DATA_W-1:0] cfg_data,
  // input byte channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pcf_pkg::in_item_t         in_data,
  // output byte channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output pcf_pkg::out_item_t        out_data
);

  import pcf_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;  // waiting for a byte
  localparam logic [2:0] S_DRAIN   = 3'd1;  // trim window to the length, then store the byte
  localparam logic [2:0] S_PASS    = 3'd2;  // zero length, send the byte as is
  localparam logic [2:0] S_RD      = 3'd3;  // read the oldest window byte
  localparam logic [2:0] S_POP     = 3'd4;  // send the oldest window byte
  localparam logic [2:0] S_CMP_RD  = 3'd5;  // read window byte at compare index
  localparam logic [2:0] S_CMP_CHK = 3'd6;  // compare it against the pattern byte
  localparam logic [2:0] S_STAR    = 3'd7;  // send one star per pattern byte

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_length;

  // sequencer and window bookkeeping
  logic [2:0]        state, state_next;
  logic [WIN_AW-1:0] head, head_next;     // oldest window entry in the ring
  logic [CNT_W-1:0]  count, count_next;   // bytes held in the window
  logic [WIN_AW-1:0] idx, idx_next;       // compare / star index
  logic              pop_drain, pop_drain_next;

  // byte being worked on
  logic [7:0] cur_byte;
  logic       cur_flush;

  // output register
  logic      out_valid_next;
  out_item_t out_data_next;
  logic      out_free;

  // derived length values
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  keep;
  logic [WIN_AW-1:0] limit_m1;

  // window ram and compare unit
  logic              ram_we;
  logic [WIN_AW-1:0] ram_wr_addr;
  logic [WIN_AW-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;
  logic [2*CFG_DATA_W-1:0] pattern_bits;
  logic [7:0]        pattern_sel;
  logic              cmp_hit;

  // active length, saturated to the window capacity
  always_comb begin
    if (int'(pattern_length) > LIMIT_CAP) begin
      limit = CNT_W'(LIMIT_CAP);
    end else begin
      limit = CNT_W'(pattern_length);
    end
    keep     = (limit == '0) ? '0 : CNT_W'(limit - CNT_W'(1));
    limit_m1 = WIN_AW'(limit - CNT_W'(1));
  end

  // the shared comparator: one window byte against one pattern byte per check
  assign pattern_bits = {pattern_high, pattern_low};
  assign pattern_sel  = pattern_bits[idx*8 +: 8];
  assign cmp_hit      = (ram_rd_data == pattern_sel);

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // new byte lands right after the held bytes
  assign ram_wr_addr = head + WIN_AW'(count);
  assign ram_rd_addr = (state == S_CMP_RD || state == S_CMP_CHK) ? WIN_AW'(head + idx) : head;

  pcf_ram #(
    .WIDTH (8),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (cur_byte),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    idx_next       = idx;
    pop_drain_next = pop_drain;
    ram_we         = 1'b0;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (count > keep) begin
          // length shrank since the last byte: shed oldest bytes first
          pop_drain_next = 1'b1;
          state_next     = S_RD;
        end else if (limit == '0) begin
          state_next = S_PASS;
        end else begin
          ram_we     = 1'b1;
          count_next = CNT_W'(count + CNT_W'(1));
          if (CNT_W'(count + CNT_W'(1)) == limit) begin
            idx_next   = '0;
            state_next = S_CMP_RD;
          end else if (cur_flush) begin
            pop_drain_next = 1'b0;
            state_next     = S_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_PASS: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{out_byte: cur_byte, run_last: 1'b1};
          state_next     = S_IDLE;
        end
      end

      S_RD: begin
        state_next = S_POP;
      end

      S_POP: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          head_next      = WIN_AW'(head + WIN_AW'(1));
          count_next     = CNT_W'(count - CNT_W'(1));
          if (pop_drain) begin
            // a drained byte is always followed by more results
            out_data_next = '{out_byte: ram_rd_data, run_last: 1'b0};
            state_next    = S_DRAIN;
          end else begin
            out_data_next = '{out_byte: ram_rd_data,
                              run_last: !cur_flush || (count == CNT_W'(1))};
            state_next    = (cur_flush && count != CNT_W'(1)) ? S_RD : S_IDLE;
          end
        end
      end

      S_CMP_RD: begin
        state_next = S_CMP_CHK;
      end

      S_CMP_CHK: begin
        if (!cmp_hit) begin
          // no match: oldest byte leaves, then the flush if any
          pop_drain_next = 1'b0;
          state_next     = S_RD;
        end else if (idx == limit_m1) begin
          idx_next   = '0;
          state_next = S_STAR;
        end else begin
          idx_next   = WIN_AW'(idx + WIN_AW'(1));
          state_next = S_CMP_RD;
        end
      end

      S_STAR: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_data_next  = '{out_byte: STAR_BYTE, run_last: idx == limit_m1};
          if (idx == limit_m1) begin
            // whole window censored, nothing left to flush
            count_next = '0;
            state_next = S_IDLE;
          end else begin
            idx_next = WIN_AW'(idx + WIN_AW'(1));
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      pop_drain <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      idx       <= idx_next;
      pop_drain <= pop_drain_next;
      out_valid <= out_valid_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    if (in_valid && in_ready) begin
      cur_byte  <= in_data.data_byte;
      cur_flush <= in_data.stream_end || (in_data.data_byte == NEWLINE_BYTE);
    end
  end

endmodule

FILE: design/pcf_checker.sv
// port level checks for the pattern censor filter, bound to the top level
`timescale 1ns / 1ps

module pcf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input pcf_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_ready,
  input pcf_pkg::out_item_t  out_data
);

  import pcf_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a byte is in work right after its transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an input transfer");

  // an open run of results keeps the input closed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.run_last |-> !in_ready)
    else $error("input taken before the run was finished");

  // reset empties the output and opens the input
  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear the block");

endmodule

bind pattern_censor_filter pcf_checker u_pcf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
